// ===== rtl/core/lstc_pkg.sv =====
// ----------------------------------------------------------------------------
// lstc_pkg
// Shared types, constants and helper functions of the lidar scan converter.
// ----------------------------------------------------------------------------
package lstc_pkg;

    localparam int LSTC_MAX_SAMPLES = 1024;

    // angle units are 1/64 degree
    localparam logic [31:0] FULL_TURN    = 32'd23040;
    localparam logic [31:0] QUARTER_TURN = 32'd5760;
    // three full turns, keeps every angle sum positive
    localparam logic [31:0] TURN_OFFSET  = 32'd69120;
    localparam logic [13:0] NO_DANGER    = 14'd10000;

    localparam logic [31:0] Q30_ONE      = 32'd1073741824;
    localparam logic [31:0] RAD_Q30      = 32'd292818;

    // floor(2^32 / d), quotient is exact after one correction step
    localparam logic [31:0] RECIP_TURN   = 32'd186413;
    localparam logic [31:0] RECIP_72     = 32'd59652323;
    localparam logic [31:0] RECIP_42     = 32'd102261126;
    localparam logic [31:0] RECIP_20     = 32'd214748364;
    localparam logic [31:0] RECIP_6      = 32'd715827882;

    localparam logic [31:0] DIV_72       = 32'd72;
    localparam logic [31:0] DIV_42       = 32'd42;
    localparam logic [31:0] DIV_20       = 32'd20;
    localparam logic [31:0] DIV_6        = 32'd6;

    localparam logic [3:0]  SINE_LAST    = 4'd9;
    localparam logic [3:0]  ANGLE_LAST   = 4'd2;
    localparam logic [3:0]  MIX_LAST     = 4'd7;
    localparam logic [1:0]  SINE_K_LAST  = 2'd3;

    typedef enum logic [2:0] {
        REG_BEAM_STEP     = 3'd0,
        REG_MOUNT_ANGLE   = 3'd1,
        REG_HEADING       = 3'd2,
        REG_MOUNT_X       = 3'd3,
        REG_MOUNT_Y       = 3'd4,
        REG_HAZARD_RADIUS = 3'd5,
        REG_RANGE_LIMIT   = 3'd6,
        REG_WALL_DEPTH    = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_SINE,
        ST_MIX,
        ST_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ANG_IDX,
        OP_RED_B,
        OP_RED_T,
        OP_SIN_X,
        OP_SIN_X2,
        OP_SIN_D72,
        OP_SIN_P,
        OP_SIN_D42,
        OP_SIN_D20,
        OP_SIN_D6,
        OP_SIN_FIN,
        OP_TR_XC,
        OP_TR_YS,
        OP_TR_XS,
        OP_TR_YC,
        OP_PT_X,
        OP_PT_Y,
        OP_WL_X,
        OP_WL_Y
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] sel;
        logic       wb;
        logic       load;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [7:0]         beam_step;
        logic signed [15:0] mount_angle;
        logic signed [15:0] heading;
        logic signed [12:0] mount_x;
        logic signed [12:0] mount_y;
        logic [15:0]        hazard_radius;
        logic [15:0]        range_limit;
        logic [15:0]        wall_depth;
    } t_cfg;

    typedef struct packed {
        logic [22:0] point_x;
        logic [22:0] point_y;
        logic [22:0] wall_x;
        logic [22:0] wall_y;
        logic        clamped;
        logic [13:0] nearest_danger;
        logic        scan_done;
    } t_result;

    typedef struct packed {
        logic [1:0]  quad;
        logic [12:0] rem;
    } t_angle;

    function automatic logic [31:0] div_fix(input logic [31:0] v, input logic [31:0] q0,
                                            input logic [31:0] d);
        logic [31:0] r;
        r = v - 32'(q0 * d);
        return (r >= d) ? q0 + 32'd1 : q0;
    endfunction

    function automatic t_angle turn_reduce(input logic [31:0] v, input logic [31:0] q0);
        logic [31:0] r;
        t_angle      a;
        r = v - 32'(q0 * FULL_TURN);
        if (r >= FULL_TURN) begin
            r = r - FULL_TURN;
        end
        priority if (r < QUARTER_TURN) begin
            a.quad = 2'd0;
            a.rem  = r[12:0];
        end else if (r < 32'(2 * QUARTER_TURN)) begin
            a.quad = 2'd1;
            a.rem  = 13'(r - QUARTER_TURN);
        end else if (r < 32'(3 * QUARTER_TURN)) begin
            a.quad = 2'd2;
            a.rem  = 13'(r - 32'(2 * QUARTER_TURN));
        end else begin
            a.quad = 2'd3;
            a.rem  = 13'(r - 32'(3 * QUARTER_TURN));
        end
        return a;
    endfunction

    // shift right by 26, rounding half away from zero
    function automatic logic [22:0] round_field(input logic signed [49:0] v);
        logic [49:0] m;
        m = v[49] ? 50'(-v) : 50'(v);
        m = (m + 50'd33554432) >> 26;
        return v[49] ? 23'(-m) : m[22:0];
    endfunction

    function automatic t_op angle_op(input logic [3:0] sub);
        t_op o;
        unique case (sub)
            4'd0:    o = OP_ANG_IDX;
            4'd1:    o = OP_RED_B;
            4'd2:    o = OP_RED_T;
            default: o = OP_NONE;
        endcase
        return o;
    endfunction

    function automatic t_op sine_op(input logic [3:0] sub);
        t_op o;
        unique case (sub)
            4'd0:    o = OP_SIN_X;
            4'd1:    o = OP_SIN_X2;
            4'd2:    o = OP_SIN_D72;
            4'd3:    o = OP_SIN_P;
            4'd4:    o = OP_SIN_D42;
            4'd5:    o = OP_SIN_P;
            4'd6:    o = OP_SIN_D20;
            4'd7:    o = OP_SIN_P;
            4'd8:    o = OP_SIN_D6;
            4'd9:    o = OP_SIN_FIN;
            default: o = OP_NONE;
        endcase
        return o;
    endfunction

    function automatic t_op mix_op(input logic [3:0] sub);
        t_op o;
        unique case (sub)
            4'd0:    o = OP_TR_XC;
            4'd1:    o = OP_TR_YS;
            4'd2:    o = OP_TR_XS;
            4'd3:    o = OP_TR_YC;
            4'd4:    o = OP_PT_X;
            4'd5:    o = OP_PT_Y;
            4'd6:    o = OP_WL_X;
            4'd7:    o = OP_WL_Y;
            default: o = OP_NONE;
        endcase
        return o;
    endfunction

endpackage

// ===== rtl/core/lstc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lstc_ctrl
// Sequencer issuing multiply and write-back steps to the datapath.
// ----------------------------------------------------------------------------
module lstc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lstc_pkg::t_sts i_sts,
    output lstc_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);
    import lstc_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_sub, n_sub;
    logic [1:0] r_k, n_k;
    logic       r_wb, n_wb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sub   <= '0;
            r_k     <= '0;
            r_wb    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sub   <= n_sub;
            r_k     <= n_k;
            r_wb    <= n_wb;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_sub      = r_sub;
        n_k        = r_k;
        n_wb       = r_wb;
        o_cmd      = '{op: OP_NONE, sel: r_k, wb: r_wb, load: 1'b0, emit: 1'b0};
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_ANGLE;
                    n_sub      = '0;
                    n_k        = '0;
                    n_wb       = 1'b0;
                end
            end
            ST_ANGLE: begin
                o_cmd.op = angle_op(r_sub);
                n_wb     = !r_wb;
                if (r_wb) begin
                    if (r_sub == ANGLE_LAST) begin
                        n_state = ST_SINE;
                        n_sub   = '0;
                    end else begin
                        n_sub = r_sub + 4'd1;
                    end
                end
            end
            ST_SINE: begin
                o_cmd.op = sine_op(r_sub);
                n_wb     = !r_wb;
                if (r_wb) begin
                    if (r_sub == SINE_LAST) begin
                        n_sub = '0;
                        if (r_k == SINE_K_LAST) begin
                            n_state = ST_MIX;
                        end else begin
                            n_k = r_k + 2'd1;
                        end
                    end else begin
                        n_sub = r_sub + 4'd1;
                    end
                end
            end
            ST_MIX: begin
                o_cmd.op = mix_op(r_sub);
                n_wb     = !r_wb;
                if (r_wb) begin
                    if (r_sub == MIX_LAST) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_sub = r_sub + 4'd1;
                    end
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/lstc_datapath.sv =====
// ----------------------------------------------------------------------------
// lstc_datapath
// Shared 32x32 multiplier, sine series registers, accumulators, result stage.
// ----------------------------------------------------------------------------
module lstc_datapath #(
    parameter int MAX_SAMPLES = lstc_pkg::LSTC_MAX_SAMPLES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lstc_pkg::t_cfg    i_cfg,
    input  lstc_pkg::t_cmd    i_cmd,
    input  logic [15:0]       i_range_cm,
    input  logic              i_end_of_scan,
    input  logic              i_out_ready,
    output logic              o_out_free,
    output logic              o_out_valid,
    output lstc_pkg::t_result o_res
);
    import lstc_pkg::*;

    localparam int IW = $clog2(MAX_SAMPLES);

    logic [IW-1:0] r_sample_idx, r_idx_cur;
    logic [13:0]   r_danger_min, n_danger_min;
    logic [16:0]   r_mag, r_wr;
    logic          r_clamped, r_last;
    logic [13:0]   r_near;

    logic [63:0]   r_prod;
    logic          r_psign;
    logic [31:0]   r_v, r_x, r_x2, r_t;
    logic [31:0]   r_sq [4];
    logic [1:0]    r_q_b, r_q_t;
    logic [12:0]   r_rem_b, r_rem_t;
    logic signed [49:0] r_tx, r_ty;
    logic [22:0]   r_px, r_py, r_wx, r_wy;

    t_result       r_out;
    logic          r_out_valid;

    logic [31:0]   mul_a, mul_b;
    logic          mul_neg;
    logic [31:0]   base_off;
    logic [31:0]   q0;
    logic [31:0]   sine_arg;
    logic signed [17:0] base_sum;
    logic [12:0]   mx_mag, my_mag;
    logic [31:0]   sb_mag, cb_mag, st_mag, ct_mag;
    logic          sb_neg, cb_neg, st_neg, ct_neg;
    logic [49:0]   prod_mag;
    logic signed [49:0] sprod;
    logic          clip;

    assign base_sum = 18'(i_cfg.mount_angle) + 18'(i_cfg.heading);
    assign base_off = 32'(base_sum) + TURN_OFFSET;
    assign q0       = r_prod[63:32];

    assign mx_mag = i_cfg.mount_x[12] ? 13'(-i_cfg.mount_x) : i_cfg.mount_x;
    assign my_mag = i_cfg.mount_y[12] ? 13'(-i_cfg.mount_y) : i_cfg.mount_y;

    // quadrant folding of the stored quarter-wave sines
    assign sb_mag = r_q_b[0] ? r_sq[1] : r_sq[0];
    assign cb_mag = r_q_b[0] ? r_sq[0] : r_sq[1];
    assign sb_neg = r_q_b[1];
    assign cb_neg = r_q_b[1] ^ r_q_b[0];
    assign st_mag = r_q_t[0] ? r_sq[3] : r_sq[2];
    assign ct_mag = r_q_t[0] ? r_sq[2] : r_sq[3];
    assign st_neg = r_q_t[1];
    assign ct_neg = r_q_t[1] ^ r_q_t[0];

    always_comb begin
        unique case (i_cmd.sel)
            2'd0: sine_arg = 32'(r_rem_b);
            2'd1: sine_arg = QUARTER_TURN - 32'(r_rem_b);
            2'd2: sine_arg = 32'(r_rem_t);
            2'd3: sine_arg = QUARTER_TURN - 32'(r_rem_t);
            default: sine_arg = '0;
        endcase
    end

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (i_cmd.op)
            OP_ANG_IDX: begin
                mul_a = 32'(r_idx_cur);
                mul_b = 32'(i_cfg.beam_step);
            end
            OP_RED_B, OP_RED_T: begin
                mul_a = r_v;
                mul_b = RECIP_TURN;
            end
            OP_SIN_X: begin
                mul_a = sine_arg;
                mul_b = RAD_Q30;
            end
            OP_SIN_X2: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            OP_SIN_D72: begin
                mul_a = r_v;
                mul_b = RECIP_72;
            end
            OP_SIN_D42: begin
                mul_a = r_v;
                mul_b = RECIP_42;
            end
            OP_SIN_D20: begin
                mul_a = r_v;
                mul_b = RECIP_20;
            end
            OP_SIN_D6: begin
                mul_a = r_v;
                mul_b = RECIP_6;
            end
            OP_SIN_P: begin
                mul_a = r_x2;
                mul_b = r_t;
            end
            OP_SIN_FIN: begin
                mul_a = r_x;
                mul_b = r_t;
            end
            OP_TR_XC: begin
                mul_a   = 32'(mx_mag);
                mul_b   = ct_mag;
                mul_neg = i_cfg.mount_x[12] ^ ct_neg;
            end
            OP_TR_YS: begin
                mul_a   = 32'(my_mag);
                mul_b   = st_mag;
                mul_neg = i_cfg.mount_y[12] ^ st_neg;
            end
            OP_TR_XS: begin
                mul_a   = 32'(mx_mag);
                mul_b   = st_mag;
                mul_neg = i_cfg.mount_x[12] ^ st_neg;
            end
            OP_TR_YC: begin
                mul_a   = 32'(my_mag);
                mul_b   = ct_mag;
                mul_neg = i_cfg.mount_y[12] ^ ct_neg;
            end
            OP_PT_X: begin
                mul_a   = 32'(r_mag);
                mul_b   = cb_mag;
                mul_neg = cb_neg;
            end
            OP_PT_Y: begin
                mul_a   = 32'(r_mag);
                mul_b   = sb_mag;
                mul_neg = sb_neg;
            end
            OP_WL_X: begin
                mul_a   = 32'(r_wr);
                mul_b   = cb_mag;
                mul_neg = cb_neg;
            end
            OP_WL_Y: begin
                mul_a   = 32'(r_wr);
                mul_b   = sb_mag;
                mul_neg = sb_neg;
            end
            default: begin
                mul_a   = '0;
                mul_b   = '0;
                mul_neg = 1'b0;
            end
        endcase
    end

    assign prod_mag = {2'b00, r_prod[47:0]};
    assign sprod    = r_psign ? -$signed(prod_mag) : $signed(prod_mag);

    assign clip = i_range_cm > i_cfg.range_limit;

    always_comb begin
        n_danger_min = r_danger_min;
        if (i_range_cm < i_cfg.hazard_radius && 14'(i_range_cm) < r_danger_min
            && i_range_cm < 16'(NO_DANGER)) begin
            n_danger_min = i_range_cm[13:0];
        end else if (i_range_cm < i_cfg.hazard_radius && i_range_cm < 16'(r_danger_min)) begin
            n_danger_min = i_range_cm[13:0];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_idx <= '0;
            r_danger_min <= NO_DANGER;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_end_of_scan) begin
                    r_sample_idx <= '0;
                    r_danger_min <= NO_DANGER;
                end else begin
                    r_sample_idx <= (r_sample_idx == IW'(MAX_SAMPLES - 1)) ? '0
                                  : r_sample_idx + IW'(1);
                    r_danger_min <= n_danger_min;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx_cur <= r_sample_idx;
            r_last    <= i_end_of_scan;
            r_clamped <= clip;
            r_mag     <= clip ? 17'(i_cfg.range_limit) : 17'(i_range_cm);
            r_wr      <= 17'(i_range_cm) + 17'(i_cfg.wall_depth);
            r_near    <= n_danger_min;
        end
        if (!i_cmd.wb && i_cmd.op != OP_NONE) begin
            r_prod  <= 64'(mul_a) * 64'(mul_b);
            r_psign <= mul_neg;
        end
        if (i_cmd.wb) begin
            unique case (i_cmd.op)
                OP_ANG_IDX: r_v <= r_prod[31:0] + base_off;
                OP_RED_B: begin
                    {r_q_b, r_rem_b} <= turn_reduce(r_v, q0);
                    r_v              <= base_off;
                end
                OP_RED_T:   {r_q_t, r_rem_t} <= turn_reduce(r_v, q0);
                OP_SIN_X:   r_x <= r_prod[31:0];
                OP_SIN_X2: begin
                    r_x2 <= r_prod[61:30];
                    r_v  <= r_prod[61:30];
                end
                OP_SIN_D72: r_t <= Q30_ONE - div_fix(r_v, q0, DIV_72);
                OP_SIN_D42: r_t <= Q30_ONE - div_fix(r_v, q0, DIV_42);
                OP_SIN_D20: r_t <= Q30_ONE - div_fix(r_v, q0, DIV_20);
                OP_SIN_D6:  r_t <= Q30_ONE - div_fix(r_v, q0, DIV_6);
                OP_SIN_P:   r_v <= r_prod[61:30];
                OP_SIN_FIN: r_sq[i_cmd.sel] <= r_prod[61:30];
                OP_TR_XC:   r_tx <= sprod;
                OP_TR_YS:   r_tx <= r_tx - sprod;
                OP_TR_XS:   r_ty <= sprod;
                OP_TR_YC:   r_ty <= r_ty + sprod;
                OP_PT_X:    r_px <= round_field(r_tx + sprod);
                OP_PT_Y:    r_py <= round_field(r_ty + sprod);
                OP_WL_X:    r_wx <= (i_cfg.wall_depth == '0) ? '0 : round_field(r_tx + sprod);
                OP_WL_Y:    r_wy <= (i_cfg.wall_depth == '0) ? '0 : round_field(r_ty + sprod);
                default: ;
            endcase
        end
        if (i_cmd.emit) begin
            r_out <= '{point_x: r_px, point_y: r_py, wall_x: r_wx, wall_y: r_wy,
                       clamped: r_clamped, nearest_danger: r_near, scan_done: r_last};
        end
    end

    assign o_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ===== rtl/core/lidar_scan_to_cartesian_unit.sv =====
// ----------------------------------------------------------------------------
// lidar_scan_to_cartesian_unit
// Lidar range samples to world x,y points with wall points and danger minimum.
// ----------------------------------------------------------------------------
// One range sample (cm) goes in per beat, one point beat comes out per sample.
// The beam angle is sample index times the beam step plus mount angle plus
// heading, taken modulo a full turn; the range is clamped to range_limit and
// turned into x,y in 1/16 cm with the rotated sensor translation added. A
// second point at range plus wall_depth is given when wall_depth is nonzero.
// nearest_danger is the running minimum of ranges below the hazard radius; it
// returns to 10000 after the beat marked tlast. A sample is worked from
// acceptance until hand-over before the next one can be accepted: a load
// step, 51 products on the single shared 32x32 multiplier (three for the
// beam angle and its reduction, ten for each of four quarter-wave sine
// series, eight for rotation and projection) each with a write-back, and a
// hand-over, waiting while the previous point beat holds the output register.
// A finished point sits in the output register while the next sample is
// already being worked. No beat is taken while reset is held. Configuration
// writes are taken in any cycle out of reset and must only be issued while
// the unit is idle.
// ----------------------------------------------------------------------------
module lidar_scan_to_cartesian_unit #(
    parameter int MAX_SAMPLES = lstc_pkg::LSTC_MAX_SAMPLES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration write channel
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    // sample input
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [15:0]   s_axis_tdata,   // [15:0] range_cm
    input  logic          s_axis_tlast,   // end_of_scan
    // point output
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [22:0] point_x, [45:23] point_y, [68:46] wall_x, [91:69] wall_y,
    // [105:92] nearest_danger, [111:106] zero
    output logic [111:0]  m_axis_tdata,
    output logic          m_axis_tuser,   // clamped
    output logic          m_axis_tlast    // scan_done
);
    import lstc_pkg::*;

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_sts    sts;
    t_result res;
    logic    out_free;
    logic    res_valid;
    logic    in_ready;

    // configuration registers, only the low bits of each write are kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{beam_step: 8'd32, mount_angle: '0, heading: '0, mount_x: '0,
                       mount_y: '0, hazard_radius: '0, range_limit: 16'hFFFF,
                       wall_depth: '0};
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_BEAM_STEP:     r_cfg.beam_step     <= i_cfg_data[7:0];
                REG_MOUNT_ANGLE:   r_cfg.mount_angle   <= i_cfg_data;
                REG_HEADING:       r_cfg.heading       <= i_cfg_data;
                REG_MOUNT_X:       r_cfg.mount_x       <= i_cfg_data[12:0];
                REG_MOUNT_Y:       r_cfg.mount_y       <= i_cfg_data[12:0];
                REG_HAZARD_RADIUS: r_cfg.hazard_radius <= i_cfg_data;
                REG_RANGE_LIMIT:   r_cfg.range_limit   <= i_cfg_data;
                REG_WALL_DEPTH:    r_cfg.wall_depth    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = i_rst_n;

    // status back to the sequencer, nothing taken while in reset
    assign sts = '{in_valid: s_axis_tvalid & i_rst_n, out_free: out_free};

    lstc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    lstc_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (cmd),
        .i_range_cm    (s_axis_tdata),
        .i_end_of_scan (s_axis_tlast),
        .i_out_ready   (m_axis_tready),
        .o_out_free    (out_free),
        .o_out_valid   (res_valid),
        .o_res         (res)
    );

    assign s_axis_tready = in_ready & i_rst_n;
    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {6'd0, res.nearest_danger, res.wall_y, res.wall_x,
                            res.point_y, res.point_x};
    assign m_axis_tuser  = res.clamped;
    assign m_axis_tlast  = res.scan_done;

    // no new sample taken while a product sequence runs
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op != OP_NONE |-> !s_axis_tready)
        else $error("sample accepted during product sequence");

    // hand-over only into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> out_free)
        else $error("result overwrote a pending beat");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> m_axis_tvalid)
        else $error("handed-over result not presented");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> cmd.op == OP_ANG_IDX && !cmd.wb)
        else $error("accepted sample did not start angle step");

endmodule
